// ===== rtl/core/fan_speed_timer_controller_core_defines.svh =====
// ----------------------------------------------------------------------------
// Fan speed timer controller - assertion macros
// Concurrent check wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef FAN_SPEED_TIMER_CONTROLLER_CORE_DEFINES_SVH
`define FAN_SPEED_TIMER_CONTROLLER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define FSTC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Checked at every edge, reset included.
`define FSTC_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define FSTC_ASSERT(label, prop, msg)
`define FSTC_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== rtl/core/fstc_pkg.sv =====
// ----------------------------------------------------------------------------
// Fan speed timer controller package
// Beat types, opcodes, register indexes and timer arithmetic constants.
// ----------------------------------------------------------------------------
`default_nettype none

package fstc_pkg;

    // Width of the off-timer total and elapsed counters
    localparam int TIME_BITS = 16;
    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

    // Timer add: wide enough for total plus a 16-bit step
    localparam int SUM_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 1;

    // Divide by 60 through a rounded-up reciprocal; exact for any value
    // below 2^TIME_BITS since the rounding error stays under 60/2^SHIFT.
    localparam int DIV60_SHIFT = TIME_BITS + 6;
    localparam logic [TIME_BITS:0] DIV60_MULT =
        (TIME_BITS+1)'(((64'd1 << DIV60_SHIFT) + 64'd59) / 64'd60);
    localparam int PROD_W = 2 * TIME_BITS + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Opcodes
    localparam logic [2:0] OP_STOP    = 3'd0;
    localparam logic [2:0] OP_LEVEL1  = 3'd1;
    localparam logic [2:0] OP_LEVEL2  = 3'd2;
    localparam logic [2:0] OP_LEVEL3  = 3'd3;
    localparam logic [2:0] OP_OSC     = 3'd4;
    localparam logic [2:0] OP_TIMER   = 3'd5;
    localparam logic [2:0] OP_SEC     = 3'd6;
    localparam logic [2:0] OP_SWEEP   = 3'd7;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DUTY1    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY2    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY3    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TSTEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SW_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SW_HIGH  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SW_STEP  = 3'd7;

    typedef struct packed {
        logic [2:0]  opcode;
        logic [31:0] now_ms;
    } in_item_t;

    typedef struct packed {
        logic [15:0] fan_duty;
        logic [1:0]  led_level;
        logic        oscillate_on;
        logic [7:0]  servo_duty;
        logic        timer_running;
        logic [10:0] remain_min;
        logic [5:0]  remain_sec;
    } out_item_t;

endpackage

`default_nettype wire

// ===== rtl/core/fan_speed_timer_controller_core.sv =====
// ----------------------------------------------------------------------------
// Fan speed timer controller core
// Event-driven fan, off-timer and servo sweep state, one result per event.
// ----------------------------------------------------------------------------
// Pipeline: two register stages; an accepted input beat waits in the input
//   register and moves to the result register when that is empty or taken.
// Throughput: one event per cycle while result beats are taken; the state
//   update is a single pass of short logic, the divide by 60 being a reciprocal multiply.
// Reset: aresetn synchronous, active low; clears both pipeline valids,
//   loads the default register values and the power-on fan state.
// ----------------------------------------------------------------------------
`default_nettype none

`include "fan_speed_timer_controller_core_defines.svh"

module fan_speed_timer_controller_core (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    // configuration write port
    input  wire logic                                cfg_wr_en,
    input  wire logic [fstc_pkg::CFG_IDX_W-1:0]      cfg_wr_index,
    input  wire logic [fstc_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
    // event input channel
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire fstc_pkg::in_item_t                  s_data,
    // result channel
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output fstc_pkg::out_item_t                      m_data
);

    localparam int TB = fstc_pkg::TIME_BITS;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [15:0] duty1_reg, duty2_reg, duty3_reg;
    logic [15:0] debounce_reg, tstep_reg;
    logic [7:0]  sw_low_reg, sw_high_reg, sw_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty1_reg    <= 16'd400;
            duty2_reg    <= 16'd700;
            duty3_reg    <= 16'd900;
            debounce_reg <= 16'd300;
            tstep_reg    <= 16'd10;
            sw_low_reg   <= 8'd50;
            sw_high_reg  <= 8'd250;
            sw_step_reg  <= 8'd5;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                fstc_pkg::REG_DUTY1:    duty1_reg    <= cfg_wr_data;
                fstc_pkg::REG_DUTY2:    duty2_reg    <= cfg_wr_data;
                fstc_pkg::REG_DUTY3:    duty3_reg    <= cfg_wr_data;
                fstc_pkg::REG_DEBOUNCE: debounce_reg <= cfg_wr_data;
                fstc_pkg::REG_TSTEP:    tstep_reg    <= cfg_wr_data;
                fstc_pkg::REG_SW_LOW:   sw_low_reg   <= cfg_wr_data[7:0];
                fstc_pkg::REG_SW_HIGH:  sw_high_reg  <= cfg_wr_data[7:0];
                fstc_pkg::REG_SW_STEP:  sw_step_reg  <= cfg_wr_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeds the result register. An event moves
    // forward (and commits its state update) when the result register is
    // empty or its beat is being taken this cycle.
    // ------------------------------------------------------------------
    logic                in_valid_reg;
    fstc_pkg::in_item_t  in_item_reg;
    logic                out_valid_reg;
    fstc_pkg::out_item_t out_item_reg;
    logic                advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_item_reg <= s_data;
        end
    end

    // ------------------------------------------------------------------
    // Fan state
    // ------------------------------------------------------------------
    logic [15:0]   duty_reg,      duty_next;
    logic [1:0]    leds_reg,      leds_next;
    logic          osc_reg,       osc_next;
    logic          run_reg,       run_next;
    logic [TB-1:0] total_reg,     total_next;
    logic [TB-1:0] elapsed_reg,   elapsed_next;
    logic [31:0]   last_ms_reg,   last_ms_next;
    logic [10:0]   shown_min_reg, shown_min_next;
    logic [5:0]    shown_sec_reg, shown_sec_next;
    logic [7:0]    pos_reg,       pos_next;
    logic          down_reg,      down_next;
    logic [7:0]    servo_reg,     servo_next;

    // Shared debounce window for the oscillate and timer buttons
    logic [31:0] since_press;
    logic        press_ok;
    assign since_press = in_item_reg.now_ms - last_ms_reg;
    assign press_ok    = (since_press >= {16'd0, debounce_reg});

    // Timer add with saturation
    logic [fstc_pkg::SUM_W-1:0] timer_sum;
    logic [TB-1:0]              timer_sat;
    assign timer_sum = fstc_pkg::SUM_W'(total_reg) + fstc_pkg::SUM_W'(tstep_reg);
    assign timer_sat = (timer_sum > fstc_pkg::SUM_W'(fstc_pkg::TIME_MAX))
                       ? fstc_pkg::TIME_MAX : timer_sum[TB-1:0];

    // Second tick: bump elapsed (saturating), check for expiry, split the
    // remaining time into minutes and seconds.
    logic [TB-1:0]                 elapsed_inc;
    logic                          expired;
    logic [TB-1:0]                 remain;
    logic [fstc_pkg::PROD_W-1:0]   div_prod;
    logic [TB-1:0]                 remain_q;
    logic [TB+5:0]                 q_times60;
    logic [TB+5:0]                 remain_r;

    assign elapsed_inc = (elapsed_reg < fstc_pkg::TIME_MAX) ? elapsed_reg + 1'b1
                                                            : elapsed_reg;
    assign expired     = (total_reg <= elapsed_inc);
    assign remain      = expired ? '0 : total_reg - elapsed_inc;
    assign div_prod    = fstc_pkg::PROD_W'(remain) * fstc_pkg::PROD_W'(fstc_pkg::DIV60_MULT);
    assign remain_q    = TB'(div_prod >> fstc_pkg::DIV60_SHIFT);
    assign q_times60   = ((TB+6)'(remain_q) << 6) - ((TB+6)'(remain_q) << 2);
    assign remain_r    = (TB+6)'(remain) - q_times60;

    // Sweep direction: lower turn checked first, so it wins when both hold
    logic       sweep_dir;
    assign sweep_dir = (pos_reg <= sw_low_reg) ? 1'b0
                     : (pos_reg >= sw_high_reg) ? 1'b1 : down_reg;

    always_comb begin
        duty_next      = duty_reg;
        leds_next      = leds_reg;
        osc_next       = osc_reg;
        run_next       = run_reg;
        total_next     = total_reg;
        elapsed_next   = elapsed_reg;
        last_ms_next   = last_ms_reg;
        shown_min_next = shown_min_reg;
        shown_sec_next = shown_sec_reg;
        pos_next       = pos_reg;
        down_next      = down_reg;
        servo_next     = servo_reg;

        case (in_item_reg.opcode)
            fstc_pkg::OP_STOP: begin
                duty_next  = 16'd0;
                leds_next  = 2'd0;
                osc_next   = 1'b0;
                run_next   = 1'b0;
                total_next = '0;
            end
            fstc_pkg::OP_LEVEL1: begin
                duty_next = duty1_reg;
                leds_next = 2'd1;
            end
            fstc_pkg::OP_LEVEL2: begin
                duty_next = duty2_reg;
                leds_next = 2'd2;
            end
            fstc_pkg::OP_LEVEL3: begin
                duty_next = duty3_reg;
                leds_next = 2'd3;
            end
            fstc_pkg::OP_OSC: begin
                // record the press even with the fan stopped
                if (press_ok) begin
                    last_ms_next = in_item_reg.now_ms;
                    osc_next     = (duty_reg != 16'd0) ? !osc_reg : 1'b0;
                end
            end
            fstc_pkg::OP_TIMER: begin
                if (press_ok) begin
                    last_ms_next = in_item_reg.now_ms;
                    if (duty_reg != 16'd0) begin
                        run_next   = 1'b1;
                        total_next = timer_sat;
                    end
                end
            end
            fstc_pkg::OP_SEC: begin
                if (run_reg) begin
                    if (expired) begin
                        // timer ran out: behave as a stop
                        duty_next    = 16'd0;
                        leds_next    = 2'd0;
                        osc_next     = 1'b0;
                        run_next     = 1'b0;
                        total_next   = '0;
                        elapsed_next = '0;
                    end else begin
                        elapsed_next = elapsed_inc;
                    end
                    shown_min_next = 11'(remain_q);
                    shown_sec_next = remain_r[5:0];
                end else begin
                    elapsed_next   = '0;
                    shown_min_next = 11'd0;
                    shown_sec_next = 6'd0;
                end
            end
            fstc_pkg::OP_SWEEP: begin
                if (osc_reg) begin
                    down_next  = sweep_dir;
                    pos_next   = sweep_dir ? pos_reg - sw_step_reg
                                           : pos_reg + sw_step_reg;
                    servo_next = pos_next;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            duty_reg      <= 16'd0;
            leds_reg      <= 2'd0;
            osc_reg       <= 1'b0;
            run_reg       <= 1'b0;
            total_reg     <= '0;
            elapsed_reg   <= '0;
            last_ms_reg   <= 32'd0;
            shown_min_reg <= 11'd0;
            shown_sec_reg <= 6'd0;
            pos_reg       <= 8'd50;
            down_reg      <= 1'b0;
            servo_reg     <= 8'd0;
        end else if (advance) begin
            duty_reg      <= duty_next;
            leds_reg      <= leds_next;
            osc_reg       <= osc_next;
            run_reg       <= run_next;
            total_reg     <= total_next;
            elapsed_reg   <= elapsed_next;
            last_ms_reg   <= last_ms_next;
            shown_min_reg <= shown_min_next;
            shown_sec_reg <= shown_sec_next;
            pos_reg       <= pos_next;
            down_reg      <= down_next;
            servo_reg     <= servo_next;
        end
    end

    // Result beat carries the state as it stands after the event
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_item_reg.fan_duty      <= duty_next;
            out_item_reg.led_level     <= leds_next;
            out_item_reg.oscillate_on  <= osc_next;
            out_item_reg.servo_duty    <= servo_next;
            out_item_reg.timer_running <= run_next;
            out_item_reg.remain_min    <= shown_min_next;
            out_item_reg.remain_sec    <= shown_sec_next;
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `FSTC_ASSERT_ALWAYS(a_reset_empties, !aresetn |=> !in_valid_reg && !out_valid_reg, "pipeline not empty after reset")
    `FSTC_ASSERT(a_leds_off_duty_zero, (leds_reg == 2'd0) |-> (duty_reg == 16'd0), "LEDs off with fan duty set")
    `FSTC_ASSERT(a_idle_timer_clear, !run_reg |-> (total_reg == '0), "timer total left while timer idle")
    `FSTC_ASSERT(a_seconds_range, shown_sec_reg < 6'd60, "shown seconds out of range")

endmodule

`default_nettype wire

// ===== tb/tb_fan_speed_timer_controller_core.sv =====
// ----------------------------------------------------------------------------
// Fan speed timer controller core - self-checking testbench
// Drives button and tick events through the valid/ready input channel, tracks
// the fan, off-timer and servo state alongside the core, and compares every
// result beat against the tracked state.
// The core is also run under several register settings, with random stalls
// on both channels.
// ----------------------------------------------------------------------------

class fan_controller_tracker;
    // register copies
    logic [15:0] level_duty [3];
    logic [15:0] debounce_ms;
    logic [15:0] step_s;
    logic [7:0]  sweep_lo;
    logic [7:0]  sweep_hi;
    logic [7:0]  sweep_inc;

    // fan state
    logic [15:0]                    duty;
    logic [1:0]                     leds;
    logic                           osc;
    logic                           running;
    logic [fstc_pkg::TIME_BITS-1:0] total;
    logic [fstc_pkg::TIME_BITS-1:0] elapsed;
    logic [31:0]                    last_press;
    logic [10:0]                    min_shown;
    logic [5:0]                     sec_shown;
    logic [7:0]                     servo_pos;
    logic                           heading_down;
    logic [7:0]                     servo_out;

    fstc_pkg::out_item_t pending_outputs [$];
    int                  errors;

    function new();
        level_duty[0] = 16'd400;
        level_duty[1] = 16'd700;
        level_duty[2] = 16'd900;
        debounce_ms   = 16'd300;
        step_s        = 16'd10;
        sweep_lo      = 8'd50;
        sweep_hi      = 8'd250;
        sweep_inc     = 8'd5;
        duty          = '0;
        leds          = '0;
        osc           = 1'b0;
        running       = 1'b0;
        total         = '0;
        elapsed       = '0;
        last_press    = '0;
        min_shown     = '0;
        sec_shown     = '0;
        servo_pos     = 8'd50;
        heading_down  = 1'b0;
        servo_out     = '0;
        errors        = 0;
    endfunction

    function void write_reg(logic [fstc_pkg::CFG_IDX_W-1:0] idx,
                            logic [fstc_pkg::CFG_DATA_W-1:0] val);
        case (idx)
            fstc_pkg::REG_DUTY1:    level_duty[0] = val;
            fstc_pkg::REG_DUTY2:    level_duty[1] = val;
            fstc_pkg::REG_DUTY3:    level_duty[2] = val;
            fstc_pkg::REG_DEBOUNCE: debounce_ms = val;
            fstc_pkg::REG_TSTEP:    step_s = val;
            fstc_pkg::REG_SW_LOW:   sweep_lo = val[7:0];
            fstc_pkg::REG_SW_HIGH:  sweep_hi = val[7:0];
            fstc_pkg::REG_SW_STEP:  sweep_inc = val[7:0];
            default: ;
        endcase
    endfunction

    function void halt();
        duty    = '0;
        leds    = '0;
        osc     = 1'b0;
        running = 1'b0;
        total   = '0;
    endfunction

    // Shared debounce for the oscillate and timer buttons.
    function bit take_press(logic [31:0] stamp);
        logic [31:0] since;
        since = stamp - last_press;
        if (since >= 32'(debounce_ms)) begin
            last_press = stamp;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function void note_event(fstc_pkg::in_item_t ev);
        logic [32:0]                    sum;
        logic [fstc_pkg::TIME_BITS-1:0] rem;
        fstc_pkg::out_item_t            res;
        case (ev.opcode)
            fstc_pkg::OP_STOP: halt();
            fstc_pkg::OP_LEVEL1, fstc_pkg::OP_LEVEL2, fstc_pkg::OP_LEVEL3: begin
                duty = level_duty[ev.opcode - fstc_pkg::OP_LEVEL1];
                leds = ev.opcode[1:0];
            end
            fstc_pkg::OP_OSC: begin
                if (take_press(ev.now_ms))
                    osc = (duty != 0) ? ~osc : 1'b0;
            end
            fstc_pkg::OP_TIMER: begin
                if (take_press(ev.now_ms) && duty != 0) begin
                    sum = 33'(total) + 33'(step_s);
                    running = 1'b1;
                    total = (sum > 33'(fstc_pkg::TIME_MAX)) ? fstc_pkg::TIME_MAX
                                                            : sum[fstc_pkg::TIME_BITS-1:0];
                end
            end
            fstc_pkg::OP_SEC: begin
                if (running) begin
                    if (elapsed < fstc_pkg::TIME_MAX)
                        elapsed = elapsed + 1'b1;
                    if (total <= elapsed) begin
                        halt();
                        elapsed = '0;
                    end
                    rem = total - elapsed;
                    min_shown = 11'(rem / 60);
                    sec_shown = 6'(rem % 60);
                end else begin
                    elapsed   = '0;
                    min_shown = '0;
                    sec_shown = '0;
                end
            end
            default: begin
                if (osc) begin
                    if (servo_pos >= sweep_hi)
                        heading_down = 1'b1;
                    if (servo_pos <= sweep_lo)
                        heading_down = 1'b0;
                    servo_pos = heading_down ? servo_pos - sweep_inc
                                             : servo_pos + sweep_inc;
                    servo_out = servo_pos;
                end
            end
        endcase
        res.fan_duty      = duty;
        res.led_level     = leds;
        res.oscillate_on  = osc;
        res.servo_duty    = servo_out;
        res.timer_running = running;
        res.remain_min    = min_shown;
        res.remain_sec    = sec_shown;
        pending_outputs.push_back(res);
    endfunction

    function void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    function void check_outputs(fstc_pkg::out_item_t got);
        fstc_pkg::out_item_t want;
        if (pending_outputs.size() == 0) begin
            errors++;
            $display("%0t: result beat with no event pending, expected none, got %h",
                     $time, got);
            return;
        end
        want = pending_outputs.pop_front();
        compare_field("fan_duty", want.fan_duty, got.fan_duty);
        compare_field("led_level", want.led_level, got.led_level);
        compare_field("oscillate_on", want.oscillate_on, got.oscillate_on);
        compare_field("servo_duty", want.servo_duty, got.servo_duty);
        compare_field("timer_running", want.timer_running, got.timer_running);
        compare_field("remain_min", want.remain_min, got.remain_min);
        compare_field("remain_sec", want.remain_sec, got.remain_sec);
    endfunction
endclass

module tb_fan_speed_timer_controller_core;

    logic                            aclk = 1'b0;
    logic                            aresetn = 1'b0;
    logic                            cfg_wr_en = 1'b0;
    logic [fstc_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [fstc_pkg::CFG_DATA_W-1:0] cfg_wr_data = '0;
    logic                            s_valid = 1'b0;
    logic                            s_ready;
    fstc_pkg::in_item_t              s_data = '0;
    logic                            m_valid;
    logic                            m_ready = 1'b0;
    fstc_pkg::out_item_t             m_data;

    fan_controller_tracker tracker = new();

    // idle percentages for the sender and the receiver
    int          send_idle_pct = 22;
    int          sink_idle_pct = 63;
    // free-running millisecond time used to stamp random events
    logic [31:0] clock_ms = '0;

    fan_speed_timer_controller_core uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Stall the result channel at random, one decision per cycle.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Watch both channels; every accepted event beat queues one expected
    // result, every accepted result beat retires the oldest one.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                tracker.check_outputs(m_data);
            if (s_valid && s_ready)
                tracker.note_event(s_data);
        end
    end

    // Idle the sender one cycle at a time at the set rate, then offer one
    // event beat; hold valid and payload until accepted.
    task automatic send_event(logic [2:0] op, logic [31:0] stamp);
        fstc_pkg::in_item_t ev;
        ev.opcode = op;
        ev.now_ms = stamp;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= ev;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Drop valid and let every expected result drain, plus the pipeline depth.
    task automatic drain();
        s_valid <= 1'b0;
        // let the monitor note the last accepted beat first
        @(posedge aclk);
        while (tracker.pending_outputs.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Write one register; the caller lowers the write enable afterwards.
    task automatic put_reg(logic [fstc_pkg::CFG_IDX_W-1:0] idx,
                           logic [fstc_pkg::CFG_DATA_W-1:0] val);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data  <= val;
        tracker.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic load_settings(logic [15:0] d1, logic [15:0] d2, logic [15:0] d3,
                                 logic [15:0] deb, logic [15:0] step,
                                 logic [7:0] lo, logic [7:0] hi, logic [7:0] inc);
        put_reg(fstc_pkg::REG_DUTY1, d1);
        put_reg(fstc_pkg::REG_DUTY2, d2);
        put_reg(fstc_pkg::REG_DUTY3, d3);
        put_reg(fstc_pkg::REG_DEBOUNCE, deb);
        put_reg(fstc_pkg::REG_TSTEP, step);
        put_reg(fstc_pkg::REG_SW_LOW, {8'd0, lo});
        put_reg(fstc_pkg::REG_SW_HIGH, {8'd0, hi});
        put_reg(fstc_pkg::REG_SW_STEP, {8'd0, inc});
        cfg_wr_en <= 1'b0;
    endtask

    // Weight the opcodes so the fan spends most of its time running, with
    // the timer and the sweep active; stop stays rare.
    function automatic logic [2:0] pick_op();
        int r;
        r = $urandom_range(99);
        if (r < 3)
            return fstc_pkg::OP_STOP;
        else if (r < 7)
            return fstc_pkg::OP_LEVEL1;
        else if (r < 11)
            return fstc_pkg::OP_LEVEL2;
        else if (r < 15)
            return fstc_pkg::OP_LEVEL3;
        else if (r < 25)
            return fstc_pkg::OP_OSC;
        else if (r < 33)
            return fstc_pkg::OP_TIMER;
        else if (r < 70)
            return fstc_pkg::OP_SEC;
        return fstc_pkg::OP_SWEEP;
    endfunction

    // Mostly advance the time by up to twice the debounce window plus two ms, so
    // presses land on both sides of it; now and then jump to any time with any opcode.
    task automatic run_random_events(int count);
        int          span;
        logic [2:0]  op;
        clock_ms = $urandom;
        for (int k = 0; k < count; k++) begin
            span = 2 * int'(tracker.debounce_ms) + 2;
            if ($urandom_range(99) < 5) begin
                op       = 3'($urandom_range(7));
                clock_ms = $urandom;
            end else begin
                op       = pick_op();
                clock_ms = clock_ms + 32'($urandom_range(0, span));
            end
            send_event(op, clock_ms);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed events on the reset register values.
        send_event(fstc_pkg::OP_SWEEP, 32'd0);          // oscillation off: nothing moves
        send_event(fstc_pkg::OP_SEC, 32'hFFFF_FFFF);    // timer off: clear shown time
        send_event(fstc_pkg::OP_OSC, 32'd300);          // fan stopped: press taken, osc off
        send_event(fstc_pkg::OP_TIMER, 32'd400);        // inside the debounce window
        send_event(fstc_pkg::OP_TIMER, 32'd700);        // taken, but no effect while stopped
        send_event(fstc_pkg::OP_LEVEL1, 32'd0);
        send_event(fstc_pkg::OP_OSC, 32'd999);          // one ms short of the window
        send_event(fstc_pkg::OP_OSC, 32'd1000);         // oscillation on
        send_event(fstc_pkg::OP_SWEEP, 32'd0);          // start at the low turn point
        send_event(fstc_pkg::OP_SWEEP, 32'd0);
        send_event(fstc_pkg::OP_LEVEL2, 32'd0);
        send_event(fstc_pkg::OP_LEVEL3, 32'd0);
        send_event(fstc_pkg::OP_TIMER, 32'hFFFF_FFFF);
        send_event(fstc_pkg::OP_TIMER, 32'h0000_012B);  // window measured across the wrap
        send_event(fstc_pkg::OP_SEC, 32'd0);
        send_event(fstc_pkg::OP_SEC, 32'd0);
        send_event(fstc_pkg::OP_OSC, 32'h0000_0300);    // oscillation off again
        send_event(fstc_pkg::OP_SWEEP, 32'd0);
        send_event(fstc_pkg::OP_STOP, 32'd0);           // elapsed count survives the stop
        send_event(fstc_pkg::OP_LEVEL1, 32'd0);
        send_event(fstc_pkg::OP_TIMER, 32'h0000_0500);  // restart on a stale elapsed count
        send_event(fstc_pkg::OP_SEC, 32'd0);
        send_event(fstc_pkg::OP_OSC, 32'h8000_0000);
        send_event(fstc_pkg::OP_STOP, 32'd0);
        send_event(fstc_pkg::OP_SEC, 32'd0);

        // Random phases, each under its own register setting; cycle the
        // idle pattern: sender light/receiver heavy, reversed, then none.
        for (int ph = 0; ph < 6; ph++) begin
            drain();
            case (ph % 3)
                0: begin
                    send_idle_pct = 22;
                    sink_idle_pct = 63;
                end
                1: begin
                    send_idle_pct = 63;
                    sink_idle_pct = 22;
                end
                default: begin
                    send_idle_pct = 0;
                    sink_idle_pct = 0;
                end
            endcase
            case (ph)
                0: load_settings(16'd1000, 16'd2000, 16'd3000, 16'd50, 16'd3,
                                 8'd20, 8'd200, 8'd7);
                1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                 8'd255, 8'd255, 8'd255);
                2: load_settings(16'd0, 16'd1, 16'hFFFF, 16'd0, 16'd1,
                                 8'd0, 8'd0, 8'd0);
                3: load_settings(16'd12345, 16'd0, 16'd777, 16'd1000, 16'd40000,
                                 8'd200, 8'd100, 8'd60);
                4: load_settings(16'd33000, 16'd65534, 16'd1, 16'd1, 16'd7,
                                 8'd10, 8'd240, 8'd13);
                default: load_settings(16'hAAAA, 16'h5555, 16'hFFFF, 16'd2000, 16'd10,
                                       8'd255, 8'd0, 8'd128);
            endcase
            run_random_events(260);
        end

        drain();
        if (tracker.errors == 0)
            $display("fan_speed_timer_controller_core test passed");
        else
            $display("fan_speed_timer_controller_core test failed");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #1000000;
        $display("fan_speed_timer_controller_core test failed");
        $finish;
    end

endmodule
